// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and sizes of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 16;
  localparam int BRK_W  = 17;
  localparam int STAT_W = 2;

  localparam int unsigned BRK_MAX = (2 ** BRK_W) - 1;
  localparam logic [BRK_W-1:0] LIMIT_RESET = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [BRK_W-1:0]  start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffba_seq.sv =====
// ----------------------------------------------------------------------------
// ffba_seq
// Request sequencer: scans the block table, updates it and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_seq #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  localparam int IDX_W       = $clog2(MAX_BLOCKS),
  localparam int ENT_W       = $bits(ffba_pkg::entry_t)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,
  input  wire logic                        in_tuser,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ffba_pkg::BRK_W-1:0]  cfg_data,
  output logic                             wr_en,
  output logic      [IDX_W-1:0]            wr_addr,
  output logic      [ENT_W-1:0]            wr_data,
  output logic                             rd_en,
  output logic      [IDX_W-1:0]            rd_addr,
  input  wire logic [ENT_W-1:0]            rd_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output ffba_pkg::res_t                   res
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int X_W   = ffba_pkg::BRK_W + 1;
  localparam int unsigned HEAP_CAP =
    (HEAP_BYTES > ffba_pkg::BRK_MAX) ? ffba_pkg::BRK_MAX : HEAP_BYTES;
  localparam logic [ffba_pkg::BRK_W-1:0] CAP     = ffba_pkg::BRK_W'(HEAP_CAP);
  localparam logic [X_W-1:0]             HDR_X   = X_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]           MAX_CNT = CNT_W'(MAX_BLOCKS);

  ffba_pkg::state_t state_r, state_nxt;

  logic                          op_r, op_nxt;
  logic [ffba_pkg::SIZE_W-1:0]   size_r, size_nxt;
  logic [ffba_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [IDX_W-1:0]              chk_r, chk_nxt;
  logic                          pend_r, pend_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [ffba_pkg::BRK_W-1:0]    brk_r, brk_nxt;
  logic [ffba_pkg::BRK_W-1:0]    lim_r;
  ffba_pkg::res_t                res_r, res_nxt;

  ffba_pkg::entry_t              rd_e, wr_e;
  logic                          accept, fast, issue, hit, miss, top, full;
  logic                          hit_alloc, hit_free;
  logic [ffba_pkg::BRK_W-1:0]    lim;
  logic [X_W-1:0]                total, room, ent_user, brk_user;
  logic [ffba_pkg::SIZE_W-1:0]   in_size;
  logic [ffba_pkg::ADDR_W-1:0]   in_addr;

  assign in_tready = (state_r == ffba_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign in_size   = in_tdata[15:0];
  assign in_addr   = in_tdata[31:16];
  assign fast      = ((in_tuser == ffba_pkg::OP_ALLOC) && (in_size == '0)) ||
                     ((in_tuser == ffba_pkg::OP_FREE) && (in_addr == '0));

  assign rd_e      = ffba_pkg::entry_t'(rd_data);
  assign issue     = (state_r == ffba_pkg::S_SCAN) && (idx_r < count_r);
  assign rd_en     = issue;
  assign rd_addr   = idx_r[IDX_W-1:0];

  assign ent_user  = {1'b0, rd_e.start} + HDR_X;
  assign brk_user  = {1'b0, brk_r} + HDR_X;
  assign hit_alloc = rd_e.free && (rd_e.size >= size_r);
  assign hit_free  = (ent_user == X_W'(addr_r));
  assign hit       = pend_r && ((op_r == ffba_pkg::OP_FREE) ? hit_free : hit_alloc);
  assign miss      = !issue && !pend_r;
  assign top       = ((CNT_W'(chk_r) + CNT_W'(1)) == count_r);

  assign lim       = (lim_r < CAP) ? lim_r : CAP;
  assign total     = X_W'(size_r) + HDR_X;
  assign room      = {1'b0, lim} - {1'b0, brk_r};
  assign full      = (count_r == MAX_CNT) || (brk_r > lim) || (total > room);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = fast ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        if (hit || miss) begin
          state_nxt = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    size_nxt  = size_r;
    addr_nxt  = addr_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    pend_nxt  = 1'b0;
    count_nxt = count_r;
    brk_nxt   = brk_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = chk_r;
    wr_e      = rd_e;
    res_valid = (state_r == ffba_pkg::S_DONE);
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt   = in_tuser;
          size_nxt = in_size;
          addr_nxt = in_addr;
          idx_nxt  = '0;
          res_nxt  = '{granted: '0,
                       status: (in_tuser == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_ZERO
                                                                : ffba_pkg::ST_OK};
        end
      end
      ffba_pkg::S_SCAN: begin
        pend_nxt = issue;
        chk_nxt  = idx_r[IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (hit) begin
          pend_nxt = 1'b0;
          res_nxt  = '{granted: '0, status: ffba_pkg::ST_OK};
          if (op_r == ffba_pkg::OP_ALLOC) begin
            wr_en       = 1'b1;
            wr_e.free   = 1'b0;
            res_nxt.granted = ent_user[ffba_pkg::ADDR_W-1:0];
          end else if (top) begin
            count_nxt = count_r - CNT_W'(1);
            brk_nxt   = brk_r - ffba_pkg::BRK_W'(X_W'(rd_e.size) + HDR_X);
          end else begin
            wr_en     = 1'b1;
            wr_e.free = 1'b1;
          end
        end else if (miss) begin
          if (op_r == ffba_pkg::OP_FREE) begin
            res_nxt = '{granted: '0, status: ffba_pkg::ST_UNKNOWN};
          end else if (full) begin
            res_nxt = '{granted: '0, status: ffba_pkg::ST_FULL};
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            wr_e      = '{start: brk_r, size: size_r, free: 1'b0};
            count_nxt = count_r + CNT_W'(1);
            brk_nxt   = ffba_pkg::BRK_W'({1'b0, brk_r} + total);
            res_nxt   = '{granted: brk_user[ffba_pkg::ADDR_W-1:0],
                          status: ffba_pkg::ST_OK};
          end
        end
      end
      ffba_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign wr_data = ENT_W'(wr_e);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
      brk_r   <= '0;
      lim_r   <= ffba_pkg::LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      brk_r   <= brk_nxt;
      if (cfg_valid && cfg_ready) begin
        lim_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    size_r <= size_nxt;
    addr_r <= addr_nxt;
    idx_r  <= idx_nxt;
    chk_r  <= chk_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ffba_obuf.sv =====
// ----------------------------------------------------------------------------
// ffba_obuf
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_obuf (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        res_valid,
  output logic                             res_ready,
  input  wire ffba_pkg::res_t              res,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [ffba_pkg::ADDR_W-1:0]      out_tdata,
  output logic [ffba_pkg::STAT_W-1:0]      out_tuser
);

  logic           valid_r, valid_nxt;
  ffba_pkg::res_t data_r;

  assign res_ready  = !valid_r || out_tready;
  assign valid_nxt  = res_valid || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.granted;
  assign out_tuser  = data_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator over an address-ordered block table in RAM.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in_      in_tvalid/in_tready    tdata: request_size, user_address; tuser: operation
//  out_     out_tvalid/out_tready  tdata: granted_address; tuser: status
//  cfg_     cfg_valid/cfg_ready    cfg_data: heap_limit
//
//  One request at a time. A zero-size allocate or a null free skips the table
//  scan; any other request scans the table through the RAM read port, one entry
//  per cycle, and stops early on a match.
//  Reset clears the entry count and break at once; no clearing pass is run.
//  A result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [31:0]                 in_tdata,   // request_size, user_address
  input  wire logic                        in_tuser,   // operation
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [ffba_pkg::ADDR_W-1:0]      out_tdata,  // granted_address
  output logic [ffba_pkg::STAT_W-1:0]      out_tuser,  // status
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ffba_pkg::BRK_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int ENT_W = $bits(ffba_pkg::entry_t);

  logic             wr_en, rd_en, res_valid, res_ready;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0] wr_data, rd_data;
  ffba_pkg::res_t   res;

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ffba_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ffba_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [ffba_pkg::ADDR_W-1:0] out_tdata,
  input wire logic [ffba_pkg::STAT_W-1:0] out_tuser
);

  logic [1:0] open_r, open_nxt;
  logic       in_acc, out_acc;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign open_nxt = open_r + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> open_r != 2'd0)
    else $error("result without a request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request accepted while another is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ffba_pkg::ST_OK |-> out_tdata == '0)
    else $error("failed request carries an address");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && open_r == 2'd0)
    else $error("result pending after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
